// ----- rtl/aie_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aie_pkg
// Shared types and constants for the ARM instruction execute block: the
// request and result transaction structs, status flag positions, condition
// codes, shift kinds and data-processing opcodes.
// ----------------------------------------------------------------------------
package aie_pkg;

    typedef struct packed {
        logic [31:0] instruction;
        logic [31:0] pc_value;
        logic [31:0] base_value;
        logic [31:0] operand_value;
        logic [31:0] shift_reg_value;
        logic [31:0] status_in;
    } req_t;

    typedef struct packed {
        logic        cond_ok;
        logic        handled;
        logic        dest_write;
        logic [3:0]  dest_index;
        logic [31:0] dest_value;
        logic [31:0] status_out;
        logic [31:0] next_pc;
    } res_t;

    // Second operand and shifter carry handed from the shifter to the ALU.
    typedef struct packed {
        logic [31:0] op2;
        logic        carry;
    } shift_res_t;

    localparam int FLAG_N_BIT = 31;
    localparam int FLAG_Z_BIT = 30;
    localparam int FLAG_C_BIT = 29;
    localparam int FLAG_V_BIT = 28;
    localparam int FLAG_T_BIT = 5;

    localparam logic [31:0] BX_MASK = 32'h0FFF_FFF0;
    localparam logic [31:0] BX_CODE = 32'h012F_FF10;

    localparam logic [3:0] REG_PC = 4'd15;
    localparam logic [3:0] REG_LR = 4'd14;

    localparam logic [3:0] MUL_SIG = 4'b1001;

    localparam logic [3:0] COND_EQ = 4'h0;
    localparam logic [3:0] COND_NE = 4'h1;
    localparam logic [3:0] COND_CS = 4'h2;
    localparam logic [3:0] COND_CC = 4'h3;
    localparam logic [3:0] COND_MI = 4'h4;
    localparam logic [3:0] COND_PL = 4'h5;
    localparam logic [3:0] COND_VS = 4'h6;
    localparam logic [3:0] COND_VC = 4'h7;
    localparam logic [3:0] COND_HI = 4'h8;
    localparam logic [3:0] COND_LS = 4'h9;
    localparam logic [3:0] COND_GE = 4'hA;
    localparam logic [3:0] COND_LT = 4'hB;
    localparam logic [3:0] COND_GT = 4'hC;
    localparam logic [3:0] COND_LE = 4'hD;
    localparam logic [3:0] COND_AL = 4'hE;

    localparam logic [1:0] SH_LSL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ASR = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    localparam logic [3:0] OP_AND = 4'h0;
    localparam logic [3:0] OP_EOR = 4'h1;
    localparam logic [3:0] OP_SUB = 4'h2;
    localparam logic [3:0] OP_RSB = 4'h3;
    localparam logic [3:0] OP_ADD = 4'h4;
    localparam logic [3:0] OP_ADC = 4'h5;
    localparam logic [3:0] OP_SBC = 4'h6;
    localparam logic [3:0] OP_RSC = 4'h7;
    localparam logic [3:0] OP_TST = 4'h8;
    localparam logic [3:0] OP_TEQ = 4'h9;
    localparam logic [3:0] OP_CMP = 4'hA;
    localparam logic [3:0] OP_CMN = 4'hB;
    localparam logic [3:0] OP_ORR = 4'hC;
    localparam logic [3:0] OP_MOV = 4'hD;
    localparam logic [3:0] OP_BIC = 4'hE;
    localparam logic [3:0] OP_MVN = 4'hF;

endpackage

// ----- rtl/arm_instruction_execute_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm_instruction_execute_top
// Execute stage for 32-bit ARM instructions: request register, one pass of
// decode, shift and ALU logic, and a result register with a done strobe.
// ----------------------------------------------------------------------------
//  Channel   Signals                  Transaction taken when
//  request   start, busy, request     rising edge with start high, busy low
//  result    done, result             rising edge ending the cycle done is high
//
//  An instruction accepted at one edge is latched as a result at the next
//  edge and shows with done for exactly one cycle. busy is always low: a
//  new instruction may be accepted every cycle, set by the single
//  register-to-register pass through the shifter, ALU and multiplier. Reset
//  clears the valid and done flags. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module arm_instruction_execute_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  aie_pkg::req_t  request,
    output logic           done,
    output aie_pkg::res_t  result
);

    logic          valid_reg;
    aie_pkg::req_t req_reg;
    logic          done_reg;
    aie_pkg::res_t result_reg;
    aie_pkg::res_t result_next;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= start && !busy;
            done_reg  <= valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= request;
        end
        if (valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    aie_exec u_exec (
        .req (req_reg),
        .res (result_next)
    );

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- rtl/aie_shifter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aie_shifter
// Barrel shifter for the data-processing second operand: rotated immediate,
// shift by immediate or by register, RRX and the zero and large amount cases.
// ----------------------------------------------------------------------------
module aie_shifter (
    input  logic [31:0]             instruction,
    input  logic [31:0]             rm,
    input  logic [31:0]             rs,
    input  logic                    shift_cin,
    output aie_pkg::shift_res_t     shift_out
);

    logic [1:0]  kind;
    logic        by_reg;
    logic [7:0]  amt;
    logic [7:0]  amt_eff;
    logic [4:0]  amt_lo;
    logic [32:0] lsl_ext;
    logic [32:0] lsr_ext;
    logic [32:0] asr_ext;
    logic [63:0] ror_ext;
    logic [63:0] imm_ext;
    logic [4:0]  imm_rot;
    logic [31:0] imm_val;
    logic [31:0] res;
    logic        c;

    assign kind    = instruction[6:5];
    assign by_reg  = instruction[4];
    assign amt     = by_reg ? rs[7:0] : {3'b000, instruction[11:7]};
    // LSR and ASR by an immediate of zero encode a shift by 32.
    assign amt_eff = (!by_reg && amt == 8'd0 && kind != aie_pkg::SH_LSL
                      && kind != aie_pkg::SH_ROR) ? 8'd32 : amt;
    assign amt_lo  = amt_eff[4:0];

    assign lsl_ext = {1'b0, rm} << amt_lo;
    assign lsr_ext = {rm, 1'b0} >> amt_lo;
    assign asr_ext = 33'($signed({rm, 1'b0}) >>> amt_lo);
    assign ror_ext = {rm, rm} >> amt_lo;

    assign imm_rot = {instruction[11:8], 1'b0};
    assign imm_ext = {24'd0, instruction[7:0], 24'd0, instruction[7:0]} >> imm_rot;
    assign imm_val = imm_ext[31:0];

    always_comb
    begin
        res = rm;
        c   = shift_cin;
        if (instruction[25])
        begin
            res = imm_val;
            if (instruction[11:8] != 4'd0)
            begin
                c = imm_val[31];
            end
        end
        else
        begin
            case (kind)
                aie_pkg::SH_LSL:
                begin
                    if (amt_eff == 8'd0)
                    begin
                        res = rm;
                    end
                    else if (amt_eff < 8'd32)
                    begin
                        res = lsl_ext[31:0];
                        c   = lsl_ext[32];
                    end
                    else if (amt_eff == 8'd32)
                    begin
                        res = 32'd0;
                        c   = rm[0];
                    end
                    else
                    begin
                        res = 32'd0;
                        c   = 1'b0;
                    end
                end
                aie_pkg::SH_LSR:
                begin
                    if (amt_eff == 8'd0)
                    begin
                        res = rm;
                    end
                    else if (amt_eff < 8'd32)
                    begin
                        res = lsr_ext[32:1];
                        c   = lsr_ext[0];
                    end
                    else if (amt_eff == 8'd32)
                    begin
                        res = 32'd0;
                        c   = rm[31];
                    end
                    else
                    begin
                        res = 32'd0;
                        c   = 1'b0;
                    end
                end
                aie_pkg::SH_ASR:
                begin
                    if (amt_eff == 8'd0)
                    begin
                        res = rm;
                    end
                    else if (amt_eff < 8'd32)
                    begin
                        res = asr_ext[32:1];
                        c   = asr_ext[0];
                    end
                    else
                    begin
                        res = {32{rm[31]}};
                        c   = rm[31];
                    end
                end
                default:
                begin
                    if (!by_reg && amt == 8'd0)
                    begin
                        // RRX: one-bit rotate through the carry.
                        res = {shift_cin, rm[31:1]};
                        c   = rm[0];
                    end
                    else if (amt != 8'd0)
                    begin
                        if (amt_lo == 5'd0)
                        begin
                            res = rm;
                            c   = rm[31];
                        end
                        else
                        begin
                            res = ror_ext[31:0];
                            c   = ror_ext[31];
                        end
                    end
                end
            endcase
        end
    end

    assign shift_out.op2   = res;
    assign shift_out.carry = c;

endmodule

// ----- rtl/aie_exec.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aie_exec
// Instruction decode, condition check and execution of branches, BX,
// MUL/MLA and data processing, producing one result transaction.
// ----------------------------------------------------------------------------
module aie_exec (
    input  aie_pkg::req_t req,
    output aie_pkg::res_t res
);

    logic [31:0] ins;
    logic [31:0] pc;
    logic [31:0] st;
    logic [31:0] pc_plus4;
    logic [31:0] pc_plus8;
    logic [31:0] rm;
    logic [31:0] rn;
    logic        flag_n;
    logic        flag_z;
    logic        flag_c;
    logic        flag_v;
    logic        is_b;
    logic        is_bx;
    logic        is_mul;
    logic        unhandled;
    logic        passed;
    logic [31:0] br_off;
    logic [31:0] mul_prod;
    logic [31:0] mul_res;
    logic [3:0]  opcode;
    logic [31:0] add_a;
    logic [31:0] add_b;
    logic        add_ci;
    logic [32:0] add_sum;
    logic        use_adder;
    logic [31:0] alu_res;
    logic        alu_c;
    logic        alu_v;
    logic        alu_wr;
    aie_pkg::shift_res_t sh;

    assign ins      = req.instruction;
    assign pc       = req.pc_value;
    assign st       = req.status_in;
    assign pc_plus4 = pc + 32'd4;
    assign pc_plus8 = pc + 32'd8;
    assign rm       = (ins[3:0] == aie_pkg::REG_PC) ? pc_plus8 : req.operand_value;
    assign rn       = (ins[19:16] == aie_pkg::REG_PC) ? pc_plus8 : req.base_value;

    assign flag_n = st[aie_pkg::FLAG_N_BIT];
    assign flag_z = st[aie_pkg::FLAG_Z_BIT];
    assign flag_c = st[aie_pkg::FLAG_C_BIT];
    assign flag_v = st[aie_pkg::FLAG_V_BIT];

    assign is_b   = (ins[27:25] == 3'b101);
    assign is_bx  = ((ins & aie_pkg::BX_MASK) == aie_pkg::BX_CODE);
    assign is_mul = (ins[27:22] == 6'd0) && (ins[7:4] == aie_pkg::MUL_SIG);
    // Loads, stores, halfword transfers, block transfers and the
    // coprocessor space are left out.
    assign unhandled = !is_b && !is_bx && !is_mul &&
                       ((ins[27:25] == 3'b100) || (ins[27:26] == 2'b01) ||
                        (ins[27:26] == 2'b11) ||
                        ((ins[27:25] == 3'b000) && ins[7] && ins[4] &&
                         (ins[7:4] != aie_pkg::MUL_SIG)));

    always_comb
    begin
        case (ins[31:28])
            aie_pkg::COND_EQ: passed = flag_z;
            aie_pkg::COND_NE: passed = !flag_z;
            aie_pkg::COND_CS: passed = flag_c;
            aie_pkg::COND_CC: passed = !flag_c;
            aie_pkg::COND_MI: passed = flag_n;
            aie_pkg::COND_PL: passed = !flag_n;
            aie_pkg::COND_VS: passed = flag_v;
            aie_pkg::COND_VC: passed = !flag_v;
            aie_pkg::COND_HI: passed = flag_c && !flag_z;
            aie_pkg::COND_LS: passed = !flag_c || flag_z;
            aie_pkg::COND_GE: passed = (flag_n == flag_v);
            aie_pkg::COND_LT: passed = (flag_n != flag_v);
            aie_pkg::COND_GT: passed = !flag_z && (flag_n == flag_v);
            aie_pkg::COND_LE: passed = flag_z || (flag_n != flag_v);
            aie_pkg::COND_AL: passed = 1'b1;
            default:          passed = 1'b0;
        endcase
    end

    aie_shifter u_shifter (
        .instruction (ins),
        .rm          (rm),
        .rs          (req.shift_reg_value),
        .shift_cin   (flag_c),
        .shift_out   (sh)
    );

    assign br_off   = {{6{ins[23]}}, ins[23:0], 2'b00};
    assign mul_prod = rm * req.shift_reg_value;
    assign mul_res  = mul_prod + (ins[21] ? req.base_value : 32'd0);

    assign opcode = ins[24:21];

    // One adder serves all arithmetic opcodes; subtraction adds the
    // inverted operand so that the carry out is the not-borrow flag.
    always_comb
    begin
        add_a     = rn;
        add_b     = sh.op2;
        add_ci    = 1'b0;
        use_adder = 1'b1;
        alu_wr    = 1'b1;
        case (opcode)
            aie_pkg::OP_SUB, aie_pkg::OP_CMP:
            begin
                add_b  = ~sh.op2;
                add_ci = 1'b1;
                alu_wr = (opcode == aie_pkg::OP_SUB);
            end
            aie_pkg::OP_RSB:
            begin
                add_a  = sh.op2;
                add_b  = ~rn;
                add_ci = 1'b1;
            end
            aie_pkg::OP_ADD: add_ci = 1'b0;
            aie_pkg::OP_CMN: alu_wr = 1'b0;
            aie_pkg::OP_ADC: add_ci = flag_c;
            aie_pkg::OP_SBC:
            begin
                add_b  = ~sh.op2;
                add_ci = flag_c;
            end
            aie_pkg::OP_RSC:
            begin
                add_a  = sh.op2;
                add_b  = ~rn;
                add_ci = flag_c;
            end
            aie_pkg::OP_TST, aie_pkg::OP_TEQ:
            begin
                use_adder = 1'b0;
                alu_wr    = 1'b0;
            end
            default: use_adder = 1'b0;
        endcase
    end

    assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_ci};

    always_comb
    begin
        alu_c = sh.carry;
        alu_v = flag_v;
        case (opcode)
            aie_pkg::OP_AND, aie_pkg::OP_TST: alu_res = rn & sh.op2;
            aie_pkg::OP_EOR, aie_pkg::OP_TEQ: alu_res = rn ^ sh.op2;
            aie_pkg::OP_ORR:                  alu_res = rn | sh.op2;
            aie_pkg::OP_MOV:                  alu_res = sh.op2;
            aie_pkg::OP_BIC:                  alu_res = rn & ~sh.op2;
            aie_pkg::OP_MVN:                  alu_res = ~sh.op2;
            default:                          alu_res = add_sum[31:0];
        endcase
        if (use_adder)
        begin
            alu_c = add_sum[32];
            alu_v = ~(add_a[31] ^ add_b[31]) & (add_a[31] ^ add_sum[31]);
        end
    end

    always_comb
    begin
        res             = '0;
        res.cond_ok     = passed;
        res.handled     = !unhandled;
        res.status_out  = st;
        res.next_pc     = pc_plus4;
        if (passed && !unhandled)
        begin
            if (is_b)
            begin
                res.next_pc = pc_plus8 + br_off;
                if (ins[24])
                begin
                    res.dest_write = 1'b1;
                    res.dest_index = aie_pkg::REG_LR;
                    res.dest_value = pc_plus4;
                end
            end
            else if (is_bx)
            begin
                res.status_out[aie_pkg::FLAG_T_BIT] = rm[0];
                res.next_pc = {rm[31:1], 1'b0};
            end
            else if (is_mul)
            begin
                res.dest_write = 1'b1;
                res.dest_index = ins[19:16];
                res.dest_value = mul_res;
                if (ins[19:16] == aie_pkg::REG_PC)
                begin
                    res.next_pc = mul_res;
                end
                if (ins[20])
                begin
                    res.status_out[aie_pkg::FLAG_N_BIT] = mul_res[31];
                    res.status_out[aie_pkg::FLAG_Z_BIT] = (mul_res == 32'd0);
                end
            end
            else
            begin
                if (alu_wr)
                begin
                    res.dest_write = 1'b1;
                    res.dest_index = ins[15:12];
                    res.dest_value = alu_res;
                    if (ins[15:12] == aie_pkg::REG_PC)
                    begin
                        res.next_pc = alu_res;
                    end
                end
                if (ins[20])
                begin
                    res.status_out[aie_pkg::FLAG_N_BIT] = alu_res[31];
                    res.status_out[aie_pkg::FLAG_Z_BIT] = (alu_res == 32'd0);
                    res.status_out[aie_pkg::FLAG_C_BIT] = alu_c;
                    res.status_out[aie_pkg::FLAG_V_BIT] = alu_v;
                end
            end
        end
    end

endmodule
